>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/kwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared constants, keyword table and request type of the keyword counter.
// ----------------------------------------------------------------------------
package kwc_pkg;

    localparam int NUM_KEYWORDS = 32;
    localparam int MAX_WORD     = 20;
    localparam int KEY_CHARS    = 8;
    localparam int COUNT_BITS   = 32;

    localparam int IDX_W  = $clog2(NUM_KEYWORDS);
    localparam int LEN_W  = 5;
    localparam int WORD_W = KEY_CHARS * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] OP_TEXT = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Characters packed with the newest byte in the low bits
    localparam logic [WORD_W-1:0] KW_TABLE [NUM_KEYWORDS] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof", "static",
        "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
    };

    typedef struct packed {
        logic             word_ended;
        logic             keyword_hit;
        logic             is_query;
        logic [IDX_W-1:0] index;
    } kwc_req_t;

endpackage

>>> rtl/kwc_word_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_word_tracker
// Word state, keyword match and counter request for each accepted item.
// ----------------------------------------------------------------------------
module kwc_word_tracker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      op,
    input  logic [7:0]                      char_byte,
    input  logic [kwc_pkg::IDX_W-1:0]       query_index,
    output kwc_pkg::kwc_req_t               req
);

    logic                             in_word_reg;
    logic                             in_word_next;
    logic [kwc_pkg::LEN_W-1:0]        len_reg;
    logic [kwc_pkg::LEN_W-1:0]        len_next;
    logic [kwc_pkg::WORD_W-1:0]       word_reg;
    logic [kwc_pkg::WORD_W-1:0]       word_next;
    logic                             is_letter;
    logic                             is_alnum;
    logic                             closing;
    logic                             match;
    logic [kwc_pkg::IDX_W-1:0]        match_idx;

    assign is_letter = ((char_byte >= "a") && (char_byte <= "z"))
                    || ((char_byte >= "A") && (char_byte <= "Z"));
    assign is_alnum  = is_letter || ((char_byte >= "0") && (char_byte <= "9"));

    always_comb
    begin
        match     = 1'b0;
        match_idx = '0;
        for (int k = 0; k < kwc_pkg::NUM_KEYWORDS; k++)
        begin
            if (!match && (word_reg == kwc_pkg::KW_TABLE[k]))
            begin
                match     = 1'b1;
                match_idx = kwc_pkg::IDX_W'(k);
            end
        end
        if (len_reg > kwc_pkg::LEN_W'(kwc_pkg::KEY_CHARS))
        begin
            match = 1'b0;
        end
    end

    always_comb
    begin
        closing      = 1'b0;
        in_word_next = in_word_reg;
        len_next     = len_reg;
        word_next    = word_reg;
        unique case (op)
            kwc_pkg::OP_TEXT:
            begin
                if (in_word_reg)
                begin
                    if (is_alnum && (len_reg < kwc_pkg::LEN_W'(kwc_pkg::MAX_WORD - 1)))
                    begin
                        if (len_reg < kwc_pkg::LEN_W'(kwc_pkg::KEY_CHARS))
                        begin
                            word_next = {word_reg[kwc_pkg::WORD_W-9:0], char_byte};
                        end
                        len_next = len_reg + kwc_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        closing = 1'b1;
                    end
                end
                else if (is_letter)
                begin
                    in_word_next = 1'b1;
                    word_next    = {{(kwc_pkg::WORD_W-8){1'b0}}, char_byte};
                    len_next     = kwc_pkg::LEN_W'(1);
                end
            end
            kwc_pkg::OP_END:
            begin
                closing = in_word_reg;
            end
            default:
            begin
                closing = 1'b0;
            end
        endcase
        if (closing)
        begin
            in_word_next = 1'b0;
            len_next     = '0;
        end
    end

    always_comb
    begin
        req.word_ended  = closing;
        req.keyword_hit = closing && match;
        req.is_query    = (op == kwc_pkg::OP_READ);
        req.index       = (op == kwc_pkg::OP_READ) ? query_index
                        : ((closing && match) ? match_idx : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            len_reg     <= '0;
            word_reg    <= '0;
        end
        else if (accept)
        begin
            in_word_reg <= in_word_next;
            len_reg     <= len_next;
            word_reg    <= word_next;
        end
    end

endmodule

>>> rtl/kwc_count_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_count_store
// Counter memory with read-modify-write, write forwarding and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kwc_count_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  kwc_pkg::kwc_req_t                 req,
    output logic                              ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              word_ended,
    output logic                              keyword_hit,
    output logic [kwc_pkg::IDX_W-1:0]         hit_index,
    output logic [31:0]                       count_value
);

    logic [kwc_pkg::COUNT_BITS-1:0]   mem [kwc_pkg::NUM_KEYWORDS];
    logic [kwc_pkg::NUM_KEYWORDS-1:0] vld_reg;
    logic [kwc_pkg::COUNT_BITS-1:0]   rd_data_reg;
    logic                             rd_vld_reg;

    kwc_pkg::kwc_req_t                s1_reg;
    logic                             s1_valid_reg;
    logic                             s1_adv;

    logic                             last_wr_valid_reg;
    logic [kwc_pkg::IDX_W-1:0]        last_wr_idx_reg;
    logic [kwc_pkg::COUNT_BITS-1:0]   last_wr_data_reg;

    logic [kwc_pkg::COUNT_BITS-1:0]   cur_count;
    logic [kwc_pkg::COUNT_BITS-1:0]   new_count;
    logic                             wr_en;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             out_ended_reg;
    logic                             out_hit_reg;
    logic [kwc_pkg::IDX_W-1:0]        out_idx_reg;
    logic [kwc_pkg::COUNT_BITS-1:0]   out_count_reg;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign ready  = !s1_valid_reg || s1_adv;
    assign wr_en  = s1_adv && s1_reg.keyword_hit;

    always_comb
    begin
        if (last_wr_valid_reg && (last_wr_idx_reg == s1_reg.index))
        begin
            cur_count = last_wr_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_count = rd_data_reg;
        end
        else
        begin
            cur_count = '0;
        end
        new_count = (cur_count == kwc_pkg::COUNT_MAX)
                  ? cur_count : cur_count + kwc_pkg::COUNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[req.index];
        end
        if (wr_en)
        begin
            mem[s1_reg.index] <= new_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg           <= '0;
            rd_vld_reg        <= 1'b0;
            last_wr_valid_reg <= 1'b0;
            last_wr_idx_reg   <= '0;
            last_wr_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                rd_vld_reg <= vld_reg[req.index];
            end
            if (wr_en)
            begin
                vld_reg[s1_reg.index] <= 1'b1;
                last_wr_valid_reg     <= 1'b1;
                last_wr_idx_reg       <= s1_reg.index;
                last_wr_data_reg      <= new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_reg       <= req;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ended_reg <= s1_reg.word_ended;
            out_hit_reg   <= s1_reg.keyword_hit;
            out_idx_reg   <= s1_reg.index;
            if (s1_reg.keyword_hit)
            begin
                out_count_reg <= new_count;
            end
            else if (s1_reg.is_query)
            begin
                out_count_reg <= cur_count;
            end
            else
            begin
                out_count_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_ended  = out_ended_reg;
    assign keyword_hit = out_hit_reg;
    assign hit_index   = out_idx_reg;
    assign count_value = 32'(out_count_reg);

    `ASSERT_CLK(a_hit_closes_word, clk, rst_n,
        (out_valid_reg && out_hit_reg) |-> out_ended_reg,
        "keyword hit without a closed word")
    `ASSERT_CLK(a_hit_count_nonzero, clk, rst_n,
        (out_valid_reg && out_hit_reg) |-> (out_count_reg != '0),
        "keyword hit reports a zero count")
    `ASSERT_CLK(a_s1_holds_on_stall, clk, rst_n,
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_reg)),
        "stage item changed while stalled")
    `ASSERT_NEVER(a_hit_and_query, clk, rst_n,
        s1_valid_reg && s1_reg.keyword_hit && s1_reg.is_query,
        "stage item is both a hit and a query")
    `ASSERT_CLK(a_write_marks_valid, clk, rst_n,
        wr_en |=> vld_reg[last_wr_idx_reg],
        "written counter not marked valid")

endmodule

>>> rtl/keyword_token_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_token_counter_unit
// Counts C keywords in a byte stream; reads back one counter per query.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one item per handshake, op selects a text
// byte, end of text, or a read of the counter at query_index.
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order. A result holds word_ended/keyword_hit for a closed word,
// hit_index with the keyword or queried number, and the updated or read count.
// An accepted item is registered in the update stage, and its result is then
// registered in the output register. Throughput: one item per cycle while the
// output is not stalled, set by the read-modify-write of the counter memory,
// with the last write forwarded to a read of the same entry.
// Stall: a held result keeps one more item in the update stage; after that
// in_ready drops until out_ready frees the output register.
// Reset: the open word is dropped and all 32 counters read as zero through
// per-entry valid bits; items are accepted right after reset.
// ----------------------------------------------------------------------------
module keyword_token_counter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [7:0]                   char_byte,
    input  logic [kwc_pkg::IDX_W-1:0]    query_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         word_ended,
    output logic                         keyword_hit,
    output logic [kwc_pkg::IDX_W-1:0]    hit_index,
    output logic [31:0]                  count_value
);

    logic              accept;
    kwc_pkg::kwc_req_t req;

    assign accept = in_valid && in_ready;

    kwc_word_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .char_byte   (char_byte),
        .query_index (query_index),
        .req         (req)
    );

    kwc_count_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (req),
        .ready       (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_ended  (word_ended),
        .keyword_hit (keyword_hit),
        .hit_index   (hit_index),
        .count_value (count_value)
    );

endmodule

>>> test/keyword_token_counter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_token_counter_unit_test
// Self-checking bench for the C keyword counter: drives text bytes, end of
// text, counter reads and the unused op through the input handshake. A
// scoreboard class tracks the open word and the 32 counters and checks
// every result, field by field and in order. The bench runs a short directed
// sequence, then random keywords, identifiers and noise, with random gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------

localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct packed {
    logic                      word_ended;
    logic                      keyword_hit;
    logic [kwc_pkg::IDX_W-1:0] hit_index;
    logic [31:0]               count_value;
} kw_result_t;

class count_scoreboard;
    localparam int MAX_WORD_LEN = 20;
    localparam int KEPT_CHARS   = 8;

    string       kw_names[32];
    bit          in_word;
    int          word_len;
    logic [7:0]  chars[KEPT_CHARS];
    logic [31:0] counts[32];
    kw_result_t  expected_q[$];
    int          errors;

    function new();
        kw_names = '{
            "auto", "break", "case", "char", "const", "continue", "default", "do",
            "double", "else", "enum", "extern", "float", "for", "goto", "if",
            "int", "long", "register", "return", "short", "signed", "sizeof",
            "static", "struct", "switch", "typedef", "union", "unsigned", "void",
            "volatile", "while"
        };
        in_word  = 1'b0;
        word_len = 0;
        errors   = 0;
        foreach (chars[i]) chars[i] = 8'd0;
        foreach (counts[i]) counts[i] = 32'd0;
    endfunction

    function bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_alnum(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9");
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function kw_result_t close_word();
        kw_result_t r;
        bit         same;
        r = '0;
        r.word_ended = 1'b1;
        in_word = 1'b0;
        if (word_len <= KEPT_CHARS) begin
            for (int k = 0; k < 32; k++) begin
                if (kw_names[k].len() == word_len) begin
                    same = 1'b1;
                    for (int j = 0; j < word_len; j++)
                        if (kw_names[k].getc(j) != chars[j])
                            same = 1'b0;
                    if (same) begin
                        if (counts[k] != 32'hFFFF_FFFF)
                            counts[k]++;
                        r.keyword_hit = 1'b1;
                        r.hit_index   = 5'(k);
                        r.count_value = counts[k];
                        break;
                    end
                end
            end
        end
        word_len = 0;
        return r;
    endfunction

    function void note_input(logic [1:0] op_i, logic [7:0] c, logic [4:0] q);
        kw_result_t r;
        r = '0;
        case (op_i)
            kwc_pkg::OP_TEXT: begin
                if (in_word) begin
                    if (is_alnum(c) && word_len < MAX_WORD_LEN - 1) begin
                        if (word_len < KEPT_CHARS)
                            chars[word_len] = c;
                        word_len++;
                    end
                    else
                        r = close_word();
                end
                else if (is_letter(c)) begin
                    in_word = 1'b1;
                    foreach (chars[i]) chars[i] = 8'd0;
                    chars[0] = c;
                    word_len = 1;
                end
            end
            kwc_pkg::OP_END: begin
                if (in_word)
                    r = close_word();
            end
            kwc_pkg::OP_READ: begin
                r.hit_index   = q;
                r.count_value = counts[q];
            end
            default: ;
        endcase
        expected_q.push_back(r);
    endfunction

    function void check_result(logic we, logic kh, logic [4:0] idx, logic [31:0] cnt);
        kw_result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: ended %0d hit %0d index %0d count %0d",
                     $time, we, kh, idx, cnt);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (we !== e.word_ended) begin
            $display("%0t: word_ended expected %0d, got %0d", $time, e.word_ended, we);
            errors++;
        end
        if (kh !== e.keyword_hit) begin
            $display("%0t: keyword_hit expected %0d, got %0d", $time, e.keyword_hit, kh);
            errors++;
        end
        if (idx !== e.hit_index) begin
            $display("%0t: hit_index expected %0d, got %0d", $time, e.hit_index, idx);
            errors++;
        end
        if (cnt !== e.count_value) begin
            $display("%0t: count_value expected %0d, got %0d", $time, e.count_value, cnt);
            errors++;
        end
    endfunction
endclass

module keyword_token_counter_unit_test;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                op;
    logic [7:0]                char_byte;
    logic [kwc_pkg::IDX_W-1:0] query_index;
    logic                      out_valid;
    logic                      out_ready;
    logic                      word_ended;
    logic                      keyword_hit;
    logic [kwc_pkg::IDX_W-1:0] hit_index;
    logic [31:0]               count_value;

    count_scoreboard sb;
    int              items_sent;
    bit              send_idle;
    bit              recv_idle;

    keyword_token_counter_unit u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .char_byte   (char_byte),
        .query_index (query_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_ended  (word_ended),
        .keyword_hit (keyword_hit),
        .hit_index   (hit_index),
        .count_value (count_value)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [4:0] rand_query();
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic send_item(input logic [1:0] o, input logic [7:0] c, input logic [4:0] q);
        int gap;
        gap = send_idle ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        char_byte   <= c;
        query_index <= q;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, c, q);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int j = 0; j < s.len(); j++)
            send_item(kwc_pkg::OP_TEXT, s.getc(j), rand_query());
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_delim();
        logic [7:0] c;
        c = rand_byte();
        while (sb.is_alnum(c))
            c = rand_byte();
        return c;
    endfunction

    function automatic logic [7:0] rand_alnum();
        logic [7:0] c;
        c = rand_byte();
        while (!sb.is_alnum(c))
            c = rand_byte();
        return c;
    endfunction

    task automatic send_random_chunk();
        int    kind;
        int    len;
        int    pos;
        string w;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            if (kind < 45) begin
                w = sb.kw_names[$urandom_range(0, 31)];
                case ($urandom_range(0, 9))
                    0: begin
                        pos = $urandom_range(0, w.len() - 1);
                        w.putc(pos, w.getc(pos) - 8'd32);
                    end
                    1: w = {w, "7"};
                    default: ;
                endcase
            end
            else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24)
                                                  : $urandom_range(1, 10);
                c = rand_alnum();
                while (!sb.is_letter(c))
                    c = rand_alnum();
                w = "";
                w = {w, "a"};
                w.putc(0, c);
                for (int j = 1; j < len; j++) begin
                    w = {w, "a"};
                    w.putc(j, rand_alnum());
                end
            end
            for (int j = 0; j < w.len(); j++) begin
                send_item(kwc_pkg::OP_TEXT, w.getc(j), rand_query());
                if ($urandom_range(0, 39) == 0)
                    send_item(kwc_pkg::OP_READ, rand_byte(), rand_query());
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    send_item(kwc_pkg::OP_TEXT, rand_delim(), rand_query());
                6, 7:
                    send_item(kwc_pkg::OP_END, rand_byte(), rand_query());
                default:
                    send_item(kwc_pkg::OP_TEXT, rand_byte(), rand_query());
            endcase
        end
        else if (kind < 85)
            send_item(kwc_pkg::OP_READ, rand_byte(), rand_query());
        else begin
            case ($urandom_range(0, 3))
                0: send_item(kwc_pkg::OP_TEXT, rand_byte(), rand_query());
                1: send_item(kwc_pkg::OP_TEXT, 8'($urandom_range("0", "9")), rand_query());
                2: send_item(OP_UNUSED, rand_byte(), rand_query());
                default:
                    send_item(kwc_pkg::OP_END, rand_byte(), rand_query());
            endcase
        end
    endtask

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = recv_idle ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(word_ended, keyword_hit, hit_index, count_value);
        end
    end

    initial begin
        #5_000_000;
        $display("keyword_token_counter_unit_test: done, errors");
        $finish;
    end

    initial begin
        sb          = new();
        items_sent  = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = kwc_pkg::OP_TEXT;
        char_byte   = 8'd0;
        query_index = '0;
        out_ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(kwc_pkg::OP_READ, 8'h00, 5'd0);
        send_item(kwc_pkg::OP_READ, 8'hFF, 5'd31);
        send_item(OP_UNUSED, 8'hFF, 5'd31);
        send_item(kwc_pkg::OP_END, 8'h00, 5'd0);
        send_item(kwc_pkg::OP_TEXT, "7", 5'd0);
        send_text("int");
        send_item(kwc_pkg::OP_READ, 8'h00, 5'd16);
        send_item(kwc_pkg::OP_TEXT, 8'hFF, 5'd31);
        send_text("do");
        send_item(kwc_pkg::OP_END, 8'hFF, 5'd31);
        send_text("Z0");
        send_item(kwc_pkg::OP_TEXT, 8'h80, 5'd0);
        send_text("continue9");
        send_item(kwc_pkg::OP_TEXT, " ", 5'd0);
        send_item(kwc_pkg::OP_READ, 8'h00, 5'd16);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 0 || phase == 2);
            recv_idle = (phase == 0 || phase == 3);
            while (items_sent < (phase + 1) * 400)
                send_random_chunk();
            drain();
        end

        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("keyword_token_counter_unit_test: done, clean");
        else
            $display("keyword_token_counter_unit_test: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/kwc_pkg.sv
rtl/kwc_word_tracker.sv
rtl/kwc_count_store.sv
rtl/keyword_token_counter_unit.sv
test/keyword_token_counter_unit_test.sv
